// File: rtl/core/nsrh_pkg.sv
// ----------------------------------------------------------------------------
// nsrh_pkg
// Shared constants, request codes and types of the nearest segment ray hit.
// ----------------------------------------------------------------------------
`default_nettype none

package nsrh_pkg;

  // table geometry
  localparam int MAX_SEGMENTS = 256;
  localparam int IDX_W        = $clog2(MAX_SEGMENTS);
  localparam int CNT_W        = $clog2(MAX_SEGMENTS + 1);
  localparam int SEG_W        = 128;

  // request codes
  localparam logic [1:0] REQ_CLEAR = 2'd0;
  localparam logic [1:0] REQ_ADD   = 2'd1;
  localparam logic [1:0] REQ_QUERY = 2'd2;

  // status codes
  localparam logic STAT_OK   = 1'b0;
  localparam logic STAT_FULL = 1'b1;

  // divider: quotient bits, step counter, dividend, divisor widths
  localparam int DIV_STEPS = 34;
  localparam int DIV_CNT_W = 6;
  localparam int DIV_N_W   = 101;
  localparam int DIV_D_W   = 67;

  // squared distance width
  localparam int DIST_W = 69;

  // ray of the current query: start point and extent
  typedef struct packed {
    logic [31:0] sx;
    logic [31:0] sy;
    logic [32:0] rx;
    logic [32:0] ry;
  } ray_t;

  // outcome of one segment test
  typedef struct packed {
    logic              done;
    logic              hit;
    logic [DIST_W-1:0] sqd;
    logic [31:0]       hx;
    logic [31:0]       hy;
  } eval_res_t;

endpackage

`default_nettype wire

// File: rtl/core/nsrh_seg_mem.sv
// ----------------------------------------------------------------------------
// nsrh_seg_mem
// Segment table: one write port, one read port, registered read data.
// ----------------------------------------------------------------------------
`default_nettype none

module nsrh_seg_mem
  import nsrh_pkg::*;
(
  input  wire logic             clk,
  input  wire logic             wr_en,
  input  wire logic [IDX_W-1:0] wr_addr,
  input  wire logic [SEG_W-1:0] wr_data,
  input  wire logic             rd_en,
  input  wire logic [IDX_W-1:0] rd_addr,
  output logic      [SEG_W-1:0] rd_data
);

  logic [SEG_W-1:0] mem [MAX_SEGMENTS];

  // write entry
  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem[wr_addr] <= wr_data;
    end
  end

  // read entry, registered read data
  always_ff @(posedge clk) begin
    if (rd_en) begin
      rd_data <= mem[rd_addr];
    end
  end

endmodule

`default_nettype wire

// File: rtl/core/nsrh_div.sv
// ----------------------------------------------------------------------------
// nsrh_div
// Restoring unsigned divider, one quotient bit per cycle.
// ----------------------------------------------------------------------------
`default_nettype none

module nsrh_div
  import nsrh_pkg::*;
(
  input  wire logic                 clk,
  input  wire logic                 rst_n,
  input  wire logic                 start,
  input  wire logic [DIV_N_W-1:0]   num,
  input  wire logic [DIV_D_W-1:0]   den,
  output logic                      done,
  output logic [DIV_STEPS-1:0]      quo
);

  logic                 busy_r;
  logic [DIV_CNT_W-1:0] cnt_r;
  logic [DIV_D_W-1:0]   rem_r;
  logic [DIV_D_W-1:0]   d_r;
  logic [DIV_STEPS-1:0] lo_r;
  logic [DIV_STEPS-1:0] q_r;
  logic                 done_r;
  logic [DIV_D_W:0]     rem_sh;
  logic                 ge;

  // trial subtract
  assign rem_sh = {rem_r, lo_r[DIV_STEPS-1]};
  assign ge     = rem_sh >= {1'b0, d_r};

  // control
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r <= 1'b0;
      done_r <= 1'b0;
      cnt_r  <= '0;
    end else begin
      done_r <= 1'b0;
      if (start) begin
        busy_r <= 1'b1;
        cnt_r  <= '0;
      end else if (busy_r) begin
        cnt_r <= cnt_r + 1'b1;
        if (cnt_r == DIV_CNT_W'(DIV_STEPS - 1)) begin
          busy_r <= 1'b0;
          done_r <= 1'b1;
        end
      end
    end
  end

  // datapath: upper dividend bits seed the remainder, lower bits shift in
  always_ff @(posedge clk) begin
    if (start) begin
      rem_r <= num[DIV_N_W-1:DIV_STEPS];
      lo_r  <= num[DIV_STEPS-1:0];
      d_r   <= den;
      q_r   <= '0;
    end else if (busy_r) begin
      rem_r <= ge ? DIV_D_W'(rem_sh - {1'b0, d_r}) : rem_sh[DIV_D_W-1:0];
      lo_r  <= {lo_r[DIV_STEPS-2:0], 1'b0};
      q_r   <= {q_r[DIV_STEPS-2:0], ge};
    end
  end

  assign done = done_r;
  assign quo  = q_r;

endmodule

`default_nettype wire

// File: rtl/core/nsrh_eval.sv
// ----------------------------------------------------------------------------
// nsrh_eval
// Tests one stored segment against the query ray: cross products on a shared
// multiplier, range checks, rounded hit offsets and squared distance.
// ----------------------------------------------------------------------------
`default_nettype none

module nsrh_eval
  import nsrh_pkg::*;
(
  input  wire logic             clk,
  input  wire logic             rst_n,
  input  wire logic             start,
  input  wire ray_t             ray,
  input  wire logic [SEG_W-1:0] seg,
  output eval_res_t             res
);

  localparam logic [4:0] E_IDLE  = 5'd0;
  localparam logic [4:0] E_P1    = 5'd1;
  localparam logic [4:0] E_P2    = 5'd2;
  localparam logic [4:0] E_P3    = 5'd3;
  localparam logic [4:0] E_P4    = 5'd4;
  localparam logic [4:0] E_P5    = 5'd5;
  localparam logic [4:0] E_P6    = 5'd6;
  localparam logic [4:0] E_FIX   = 5'd7;
  localparam logic [4:0] E_SIGN  = 5'd8;
  localparam logic [4:0] E_CHK   = 5'd9;
  localparam logic [4:0] E_MX0   = 5'd10;
  localparam logic [4:0] E_MX1   = 5'd11;
  localparam logic [4:0] E_MY0   = 5'd12;
  localparam logic [4:0] E_MY1   = 5'd13;
  localparam logic [4:0] E_DINIT = 5'd14;
  localparam logic [4:0] E_DIV   = 5'd15;
  localparam logic [4:0] E_SQX   = 5'd16;
  localparam logic [4:0] E_SQY   = 5'd17;
  localparam logic [4:0] E_SUM   = 5'd18;

  logic [4:0] st_r, st_nxt;

  logic [32:0] ex_r, ey_r, wx_r, wy_r;
  logic signed [66:0] den_r, c1_r, c2_r;
  logic [98:0] numx_r, numy_r;
  logic [DIST_W-1:0] dist_r;
  logic signed [34:0] mul_a, mul_b;
  logic signed [69:0] prod_r;
  logic [32:0] rxm, rym;
  logic div_start;
  logic dvx_done, dvy_done;
  logic [DIV_STEPS-1:0] qx, qy;
  logic [34:0] ox, oy;
  logic pass;
  eval_res_t res_r;

  // ray extent magnitudes
  assign rxm = ray.rx[32] ? 33'(-ray.rx) : ray.rx;
  assign rym = ray.ry[32] ? 33'(-ray.ry) : ray.ry;

  // both parameters within [0,1] of the denominator
  assign pass = !c1_r[66] && (c1_r <= den_r) && !c2_r[66] && (c2_r <= den_r);

  // signed offsets from the rounded magnitudes
  assign ox = (ray.rx[32] && (numx_r != '0)) ? 35'(-{1'b0, qx}) : {1'b0, qx};
  assign oy = (ray.ry[32] && (numy_r != '0)) ? 35'(-{1'b0, qy}) : {1'b0, qy};

  // select multiplier operands
  always_comb begin
    mul_a = '0;
    mul_b = '0;
    case (st_r)
      E_P1:  begin mul_a = {{2{ray.rx[32]}}, ray.rx}; mul_b = {{2{ey_r[32]}}, ey_r}; end
      E_P2:  begin mul_a = {{2{ray.ry[32]}}, ray.ry}; mul_b = {{2{ex_r[32]}}, ex_r}; end
      E_P3:  begin mul_a = {{2{wx_r[32]}}, wx_r};     mul_b = {{2{ey_r[32]}}, ey_r}; end
      E_P4:  begin mul_a = {{2{wy_r[32]}}, wy_r};     mul_b = {{2{ex_r[32]}}, ex_r}; end
      E_P5:  begin mul_a = {{2{wx_r[32]}}, wx_r};     mul_b = {{2{ray.ry[32]}}, ray.ry}; end
      E_P6:  begin mul_a = {{2{wy_r[32]}}, wy_r};     mul_b = {{2{ray.rx[32]}}, ray.rx}; end
      E_MX0: begin mul_a = {1'b0, c1_r[33:0]};        mul_b = {2'b0, rxm}; end
      E_MX1: begin mul_a = {2'b0, c1_r[66:34]};       mul_b = {2'b0, rxm}; end
      E_MY0: begin mul_a = {1'b0, c1_r[33:0]};        mul_b = {2'b0, rym}; end
      E_MY1: begin mul_a = {2'b0, c1_r[66:34]};       mul_b = {2'b0, rym}; end
      E_SQX: begin mul_a = {1'b0, qx};                mul_b = {1'b0, qx}; end
      E_SQY: begin mul_a = {1'b0, qy};                mul_b = {1'b0, qy}; end
      default: begin mul_a = '0; mul_b = '0; end
    endcase
  end

  // registered product
  always_ff @(posedge clk) begin
    prod_r <= mul_a * mul_b;
  end

  // next state
  always_comb begin
    st_nxt = st_r;
    case (st_r)
      E_IDLE:  if (start) st_nxt = E_P1;
      E_P1:    st_nxt = E_P2;
      E_P2:    st_nxt = E_P3;
      E_P3:    st_nxt = E_P4;
      E_P4:    st_nxt = E_P5;
      E_P5:    st_nxt = E_P6;
      E_P6:    st_nxt = E_FIX;
      E_FIX:   st_nxt = E_SIGN;
      E_SIGN:  st_nxt = (den_r == '0) ? E_IDLE : E_CHK;
      E_CHK:   st_nxt = pass ? E_MX0 : E_IDLE;
      E_MX0:   st_nxt = E_MX1;
      E_MX1:   st_nxt = E_MY0;
      E_MY0:   st_nxt = E_MY1;
      E_MY1:   st_nxt = E_DINIT;
      E_DINIT: st_nxt = E_DIV;
      E_DIV:   if (dvx_done) st_nxt = E_SQX;
      E_SQX:   st_nxt = E_SQY;
      E_SQY:   st_nxt = E_SUM;
      E_SUM:   st_nxt = E_IDLE;
      default: st_nxt = E_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      st_r <= E_IDLE;
    end else begin
      st_r <= st_nxt;
    end
  end

  // accumulate cross products, normalize sign, build numerators
  always_ff @(posedge clk) begin
    case (st_r)
      E_IDLE: begin
        ex_r <= {seg[63], seg[63:32]} - {seg[127], seg[127:96]};
        ey_r <= {seg[31], seg[31:0]} - {seg[95], seg[95:64]};
        wx_r <= {seg[127], seg[127:96]} - {ray.sx[31], ray.sx};
        wy_r <= {seg[95], seg[95:64]} - {ray.sy[31], ray.sy};
      end
      E_P2:  den_r <= prod_r[66:0];
      E_P3:  den_r <= den_r - prod_r[66:0];
      E_P4:  c1_r  <= prod_r[66:0];
      E_P5:  c1_r  <= c1_r - prod_r[66:0];
      E_P6:  c2_r  <= prod_r[66:0];
      E_FIX: c2_r  <= c2_r - prod_r[66:0];
      E_SIGN: begin
        if (den_r[66]) begin
          den_r <= -den_r;
          c1_r  <= -c1_r;
          c2_r  <= -c2_r;
        end
      end
      E_MX1: numx_r <= {31'b0, prod_r[67:0]};
      E_MY0: numx_r <= numx_r + {prod_r[64:0], 34'b0};
      E_MY1: numy_r <= {31'b0, prod_r[67:0]};
      E_DINIT: numy_r <= numy_r + {prod_r[64:0], 34'b0};
      E_SQY: dist_r <= DIST_W'(prod_r[67:0]);
      default: ;
    endcase
  end

  assign div_start = (st_r == E_DINIT);

  // round(num/den): (2*num + den) / (2*den)
  nsrh_div u_div_x (
    .clk   (clk),
    .rst_n (rst_n),
    .start (div_start),
    .num   (DIV_N_W'({numx_r, 1'b0}) + DIV_N_W'(den_r[65:0])),
    .den   ({den_r[65:0], 1'b0}),
    .done  (dvx_done),
    .quo   (qx)
  );

  nsrh_div u_div_y (
    .clk   (clk),
    .rst_n (rst_n),
    .start (div_start),
    .num   (DIV_N_W'({numy_r + {prod_r[64:0], 34'b0}, 1'b0}) + DIV_N_W'(den_r[65:0])),
    .den   ({den_r[65:0], 1'b0}),
    .done  (dvy_done),
    .quo   (qy)
  );

  // report the segment outcome
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      res_r.done <= 1'b0;
      res_r.hit  <= 1'b0;
    end else begin
      res_r.done <= 1'b0;
      if ((st_r == E_SIGN && den_r == '0) || (st_r == E_CHK && !pass)) begin
        res_r.done <= 1'b1;
        res_r.hit  <= 1'b0;
      end else if (st_r == E_SUM) begin
        res_r.done <= 1'b1;
        res_r.hit  <= 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (st_r == E_SUM) begin
      res_r.sqd <= dist_r + DIST_W'(prod_r[67:0]);
      res_r.hx  <= ray.sx + ox[31:0];
      res_r.hy  <= ray.sy + oy[31:0];
    end
  end

  assign res = res_r;

`ifndef SYNTHESIS
  // both dividers run in lockstep
  a_div_lockstep: assert property (@(posedge clk) disable iff (!rst_n)
    dvx_done == dvy_done) else $error("divider lanes out of step");
  // an accepted hit never has a negative denominator left
  a_den_pos: assert property (@(posedge clk) disable iff (!rst_n)
    (st_r == E_MX0) |-> !den_r[66] && (den_r != '0)) else $error("denominator not positive");
  // a finished test ends the evaluation
  a_done_idle: assert property (@(posedge clk) disable iff (!rst_n)
    res_r.done |-> st_r == E_IDLE) else $error("result while busy");
`endif

endmodule

`default_nettype wire

// File: rtl/core/nearest_segment_ray_hit.sv
// ----------------------------------------------------------------------------
// nearest_segment_ray_hit
// Segment table with nearest ray hit search over all stored segments.
//
//   channel  direction  fields
//   in_      input      req_type, point_a_x/y, point_b_x/y
//   out_     output     hit_found, hit_x, hit_y, status
//
// Clear and add go straight to the output stage. A query reads every stored
// segment in turn: per hit segment one table read, twelve shared multiplier
// passes and two 34-step dividers in parallel; a parallel segment ends after
// the sign step and one outside the ray or segment span after the range check.
// A query on an empty table is answered like a clear. Reset empties the table
// at once (no clearing pass). A finished result waits in the output register
// while out_stall is high; the next item is taken while it waits.
// ----------------------------------------------------------------------------
`default_nettype none

module nearest_segment_ray_hit
  import nsrh_pkg::*;
(
  input  wire logic        clk,
  input  wire logic        rst_n,
  input  wire logic        in_valid,
  output logic             in_stall,
  input  wire logic [1:0]  in_req_type,
  input  wire logic [31:0] in_point_a_x,
  input  wire logic [31:0] in_point_a_y,
  input  wire logic [31:0] in_point_b_x,
  input  wire logic [31:0] in_point_b_y,
  output logic             out_valid,
  input  wire logic        out_stall,
  output logic             out_hit_found,
  output logic [31:0]      out_hit_x,
  output logic [31:0]      out_hit_y,
  output logic             out_status
);

  localparam logic [2:0] S_IDLE  = 3'd0;
  localparam logic [2:0] S_QRD   = 3'd1;
  localparam logic [2:0] S_QST   = 3'd2;
  localparam logic [2:0] S_QWAIT = 3'd3;
  localparam logic [2:0] S_DONE  = 3'd4;

  logic [2:0] st_r, st_nxt;
  logic [CNT_W-1:0] cnt_r;
  logic [CNT_W-1:0] idx_r;
  ray_t ray_r;
  logic found_r, status_r;
  logic [31:0] hx_r, hy_r;
  logic [DIST_W-1:0] best_r;
  logic accept, slot_free, wr_en, last;
  logic [SEG_W-1:0] rd_data;
  eval_res_t res;
  logic out_valid_r, out_found_r, out_status_r;
  logic [31:0] out_x_r, out_y_r;

  assign in_stall  = (st_r != S_IDLE);
  assign accept    = in_valid && !in_stall;
  assign slot_free = !out_valid_r || !out_stall;
  assign wr_en     = accept && (in_req_type == REQ_ADD) && (cnt_r < CNT_W'(MAX_SEGMENTS));
  assign last      = (idx_r + 1'b1) == cnt_r;

  nsrh_seg_mem u_mem (
    .clk     (clk),
    .wr_en   (wr_en),
    .wr_addr (cnt_r[IDX_W-1:0]),
    .wr_data ({in_point_a_x, in_point_a_y, in_point_b_x, in_point_b_y}),
    .rd_en   (st_r == S_QRD),
    .rd_addr (idx_r[IDX_W-1:0]),
    .rd_data (rd_data)
  );

  nsrh_eval u_eval (
    .clk   (clk),
    .rst_n (rst_n),
    .start (st_r == S_QST),
    .ray   (ray_r),
    .seg   (rd_data),
    .res   (res)
  );

  // sequence requests
  always_comb begin
    st_nxt = st_r;
    case (st_r)
      S_IDLE: begin
        if (accept) begin
          st_nxt = (in_req_type == REQ_QUERY && cnt_r != '0) ? S_QRD : S_DONE;
        end
      end
      S_QRD:   st_nxt = S_QST;
      S_QST:   st_nxt = S_QWAIT;
      S_QWAIT: if (res.done) st_nxt = last ? S_DONE : S_QRD;
      S_DONE:  if (slot_free) st_nxt = S_IDLE;
      default: st_nxt = S_IDLE;
    endcase
  end

  // control state and table fill count
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      st_r  <= S_IDLE;
      cnt_r <= '0;
    end else begin
      st_r <= st_nxt;
      if (accept && in_req_type == REQ_CLEAR) begin
        cnt_r <= '0;
      end else if (wr_en) begin
        cnt_r <= cnt_r + 1'b1;
      end
    end
  end

  // capture ray, track nearest hit
  always_ff @(posedge clk) begin
    if (accept) begin
      ray_r.sx <= in_point_a_x;
      ray_r.sy <= in_point_a_y;
      ray_r.rx <= {in_point_b_x[31], in_point_b_x} - {in_point_a_x[31], in_point_a_x};
      ray_r.ry <= {in_point_b_y[31], in_point_b_y} - {in_point_a_y[31], in_point_a_y};
      idx_r    <= '0;
      found_r  <= 1'b0;
      hx_r     <= '0;
      hy_r     <= '0;
      best_r   <= '0;
      status_r <= (in_req_type == REQ_ADD && !wr_en) ? STAT_FULL : STAT_OK;
    end else if (st_r == S_QWAIT && res.done) begin
      idx_r <= idx_r + 1'b1;
      if (res.hit && (!found_r || res.sqd < best_r)) begin
        found_r <= 1'b1;
        best_r  <= res.sqd;
        hx_r    <= res.hx;
        hy_r    <= res.hy;
      end
    end
  end

  // output register
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (st_r == S_DONE && slot_free) begin
      out_valid_r <= 1'b1;
    end else if (!out_stall) begin
      out_valid_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (st_r == S_DONE && slot_free) begin
      out_found_r  <= found_r;
      out_x_r      <= hx_r;
      out_y_r      <= hy_r;
      out_status_r <= status_r;
    end
  end

  assign out_valid     = out_valid_r;
  assign out_hit_found = out_found_r;
  assign out_hit_x     = out_x_r;
  assign out_hit_y     = out_y_r;
  assign out_status    = out_status_r;

`ifndef SYNTHESIS
  a_cnt_max: assert property (@(posedge clk) disable iff (!rst_n)
    cnt_r <= CNT_W'(MAX_SEGMENTS)) else $error("table count overflow");
  a_res_wait: assert property (@(posedge clk) disable iff (!rst_n)
    res.done |-> st_r == S_QWAIT) else $error("segment result outside query");
  a_miss_zero: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid_r && !out_found_r) |-> (out_x_r == '0 && out_y_r == '0))
    else $error("miss with nonzero point");
  a_full_nohit: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid_r && out_status_r == STAT_FULL) |-> !out_found_r)
    else $error("dropped add reports a hit");
`endif

endmodule

`default_nettype wire
